[rtl/core/bfdh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfdh_pkg: shared types and constants of the double-hash bloom filter
// Payload structs, command codes, mixer constants, controller state and the
// control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bfdh_pkg;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key;
  } bfdh_in_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] query_total;
    logic [63:0] pass_total;
    logic [63:0] confirm_total;
  } bfdh_out_t;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_QUERY   = 2'd1;
  localparam logic [1:0] CMD_CONFIRM = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  localparam int         SIZE_W          = 5;
  localparam logic [4:0] SIZE_LOG2_RESET = 5'd20;
  localparam int         MIN_SIZE_LOG2   = 6;

  // splitmix64 finalizer
  localparam logic [63:0] MIX_C1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2  = 64'h94d049bb133111eb;
  localparam int          MIX_SH0 = 30;
  localparam int          MIX_SH1 = 27;
  localparam int          MIX_SH2 = 31;

  // which 32x32 partial product of a 64x64 (low half) multiply
  typedef enum logic [1:0] {
    MIX_LL,
    MIX_LH,
    MIX_HL
  } bfdh_mix_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MIX,
    S_PROBE,
    S_DONE
  } bfdh_state_t;

  typedef struct packed {
    logic      clr_en;
    logic      load;
    logic      mix_en;
    bfdh_mix_t mix_part;
    logic      mix_round;
    logic      probe_en;
    logic      finish;
  } bfdh_ctl_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } bfdh_sts_t;

endpackage
`default_nettype wire

[rtl/core/bfdh_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfdh_ctrl: bloom filter sequencer
// Clears after reset; steps insert/query through mixing, probing, result load.
// ----------------------------------------------------------------------------
module bfdh_ctrl import bfdh_pkg::*; #(
  parameter int NUM_HASHES = 7
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_command,
  output logic            in_ready,
  input  wire bfdh_sts_t  sts,
  output bfdh_ctl_t       ctl
);

  localparam int PW = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
  localparam logic [2:0]    MIX_LAST = 3'd5;
  localparam logic [PW-1:0] PRB_LAST = PW'(NUM_HASHES - 1);

  bfdh_state_t   state_r, state_nxt;
  logic [2:0]    mix_cnt_r, mix_cnt_nxt;
  logic [PW-1:0] prb_cnt_r, prb_cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_command inside {CMD_INSERT, CMD_QUERY}) state_nxt = S_MIX;
          else state_nxt = S_DONE;
        end
      end
      S_MIX: begin
        if (mix_cnt_r == MIX_LAST) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (prb_cnt_r == PRB_LAST) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    mix_cnt_nxt = (state_r == S_MIX && state_nxt == S_MIX) ? mix_cnt_r + 3'd1 : '0;
    prb_cnt_nxt = (state_r == S_PROBE && state_nxt == S_PROBE) ? prb_cnt_r + PW'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      mix_cnt_r <= '0;
      prb_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      mix_cnt_r <= mix_cnt_nxt;
      prb_cnt_r <= prb_cnt_nxt;
    end
  end

  always_comb begin
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: ctl.clr_en = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      S_MIX: begin
        ctl.mix_en = 1'b1;
        case (mix_cnt_r)
          3'd0: begin ctl.mix_part = MIX_LL; ctl.mix_round = 1'b0; end
          3'd1: begin ctl.mix_part = MIX_LH; ctl.mix_round = 1'b0; end
          3'd2: begin ctl.mix_part = MIX_HL; ctl.mix_round = 1'b0; end
          3'd3: begin ctl.mix_part = MIX_LL; ctl.mix_round = 1'b1; end
          3'd4: begin ctl.mix_part = MIX_LH; ctl.mix_round = 1'b1; end
          3'd5: begin ctl.mix_part = MIX_HL; ctl.mix_round = 1'b1; end
          default: begin ctl.mix_part = MIX_LL; ctl.mix_round = 1'b0; end
        endcase
      end
      S_PROBE: ctl.probe_en = 1'b1;
      S_DONE:  ctl.finish = sts.out_free;
      default: ctl = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/bfdh_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfdh_dpath: bloom filter datapath
// Shared 32x32 multiplier for the key mixer, probe address walk, single-port
// bit memory, statistics counters, size register and result register.
// ----------------------------------------------------------------------------
module bfdh_dpath import bfdh_pkg::*; #(
  parameter int MAX_SIZE_LOG2 = 20
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bfdh_in_t          in_data,
  input  wire logic              cfg_valid,
  input  wire logic [SIZE_W-1:0] cfg_data,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output bfdh_out_t              out_data,
  input  wire bfdh_ctl_t         ctl,
  output bfdh_sts_t              sts
);

  localparam int    AW    = MAX_SIZE_LOG2;
  localparam longint DEPTH = longint'(1) << AW;

  logic [SIZE_W-1:0] size_log2_r;
  logic [1:0]        op_r;
  logic [63:0]       v_r, acc_r;
  logic [AW-1:0]     pos_r, h2_r, clr_addr_r;
  logic              rd_q_r, rd_pend_r, all_set_r;
  logic [63:0]       q_cnt_r, p_cnt_r, c_cnt_r;
  logic              out_valid_r;
  bfdh_out_t         out_r;

  logic bit_mem [0:DEPTH-1];

  // ---- probe mask from the clamped size ----
  logic [5:0]    lg_c;
  logic [AW-1:0] mask_c;

  always_comb begin
    if (size_log2_r < SIZE_W'(MIN_SIZE_LOG2)) lg_c = 6'(MIN_SIZE_LOG2);
    else if ({1'b0, size_log2_r} > 6'(AW))    lg_c = 6'(AW);
    else                                      lg_c = {1'b0, size_log2_r};
    mask_c = ~({AW{1'b1}} << lg_c);
  end

  // ---- mixer: one partial product per cycle ----
  logic [63:0] c_sel, prod, sum, mixed;
  logic [31:0] mul_a, mul_b;

  always_comb begin
    c_sel = ctl.mix_round ? MIX_C2 : MIX_C1;
    case (ctl.mix_part)
      MIX_LL:  begin mul_a = v_r[31:0];  mul_b = c_sel[31:0];  end
      MIX_LH:  begin mul_a = v_r[31:0];  mul_b = c_sel[63:32]; end
      MIX_HL:  begin mul_a = v_r[63:32]; mul_b = c_sel[31:0];  end
      default: begin mul_a = v_r[31:0];  mul_b = c_sel[31:0];  end
    endcase
    prod  = {32'd0, mul_a} * {32'd0, mul_b};
    sum   = acc_r + {prod[31:0], 32'd0};
    mixed = ctl.mix_round ? (sum ^ (sum >> MIX_SH2)) : (sum ^ (sum >> MIX_SH1));
  end

  // ---- bit memory port ----
  logic [AW-1:0] mem_addr;
  logic          mem_we, mem_wd, mem_re;

  always_comb begin
    mem_addr = ctl.clr_en ? clr_addr_r : (pos_r & mask_c);
    mem_we   = ctl.clr_en | (ctl.probe_en & (op_r == CMD_INSERT));
    mem_wd   = ~ctl.clr_en;
    mem_re   = ctl.probe_en & (op_r == CMD_QUERY);
  end

  always_ff @(posedge clk) begin
    if (mem_we) bit_mem[mem_addr] <= mem_wd;
    if (mem_re) rd_q_r <= bit_mem[mem_addr];
  end

  // ---- result ----
  logic        hit_c, is_query, is_conf;
  logic [63:0] q_cnt_nxt, p_cnt_nxt, c_cnt_nxt;

  always_comb begin
    hit_c     = all_set_r & (~rd_pend_r | rd_q_r);
    is_query  = (op_r == CMD_QUERY);
    is_conf   = (op_r == CMD_CONFIRM);
    q_cnt_nxt = q_cnt_r + 64'(is_query);
    p_cnt_nxt = p_cnt_r + 64'(is_query & hit_c);
    c_cnt_nxt = c_cnt_r + 64'(is_conf);
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v_r  <= in_data.key ^ (in_data.key >> MIX_SH0);
      op_r <= in_data.command;
    end
    if (ctl.mix_en) begin
      case (ctl.mix_part)
        MIX_LL: acc_r <= prod;
        MIX_LH: acc_r <= sum;
        MIX_HL: begin
          v_r <= mixed;
          if (ctl.mix_round) begin
            pos_r <= mixed[AW-1:0];
            h2_r  <= mixed[32 +: AW] | AW'(1);
          end
        end
        default: acc_r <= acc_r;
      endcase
    end
    if (ctl.probe_en) pos_r <= pos_r + h2_r;
    all_set_r <= ctl.load ? 1'b1 : hit_c;
    if (ctl.finish) begin
      out_r.hit           <= is_query & hit_c;
      out_r.query_total   <= q_cnt_nxt;
      out_r.pass_total    <= p_cnt_nxt;
      out_r.confirm_total <= c_cnt_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r <= SIZE_LOG2_RESET;
      clr_addr_r  <= '0;
      rd_pend_r   <= 1'b0;
      q_cnt_r     <= '0;
      p_cnt_r     <= '0;
      c_cnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid)  size_log2_r <= cfg_data;
      if (ctl.clr_en) clr_addr_r  <= clr_addr_r + AW'(1);
      rd_pend_r <= mem_re;
      if (ctl.finish) begin
        q_cnt_r <= q_cnt_nxt;
        p_cnt_r <= p_cnt_nxt;
        c_cnt_r <= c_cnt_nxt;
      end
      if (ctl.finish)     out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign sts.clr_last = (clr_addr_r == {AW{1'b1}});
  assign sts.out_free = ~out_valid_r | out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule
`default_nettype wire

[rtl/core/bloom_filter_double_hash_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_top: bloom filter with splitmix64 double hashing
// Insert / query / confirm / read-stats over a single-port bit memory.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  in       | in_valid / in_ready  | in_data  (command, key)
//  out      | out_valid/ out_ready | out_data (hit, three 64b counters)
//  cfg      | cfg_valid/ cfg_ready | cfg_data (size_log2, 5b)
//
// Insert and query: accept, six partial products on the shared 32x32
//   multiplier for the two 64b products of the mixer, one probe per cycle
//   on the single-port bit memory for each of NUM_HASHES hashes, then result
//   load. Confirm and read-stats: accept, then result load.
// After reset the bit memory is cleared, all 2**MAX_SIZE_LOG2 bits, one per
//   cycle, with in_ready low; cfg writes are taken at any time.
// A result held by out_ready low does not block the next transaction's mixing
//   and probing; it waits only in its result-load cycle.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_top import bfdh_pkg::*; #(
  parameter int NUM_HASHES    = 7,
  parameter int MAX_SIZE_LOG2 = 20
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bfdh_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bfdh_out_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] cfg_data
);

  bfdh_ctl_t ctl;
  bfdh_sts_t sts;

  // size register is a plain write, never busy
  assign cfg_ready = 1'b1;

  // sequencer: clear pass, mix steps, probe count, result handoff
  bfdh_ctrl #(
    .NUM_HASHES (NUM_HASHES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_ready   (in_ready),
    .sts        (sts),
    .ctl        (ctl)
  );

  // mixer, address walk, bit memory, counters, result register
  bfdh_dpath #(
    .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .ctl       (ctl),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  // one transaction in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("bfdh: input taken while a transaction is in flight");

  // a result is only loaded from the result-load step, never while idle
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("bfdh: result appeared outside the result-load step");

  // a hit is always counted in the pass total
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |-> (out_data.pass_total != 64'd0))
    else $error("bfdh: hit reported without a counted pass");
`endif

endmodule
`default_nettype wire
